>>> src/lmbs_pkg.sv
package lmbs_pkg;

	// Panel geometry and plane count
	localparam int MATRIX_COLUMNS = 64;
	localparam int MATRIX_ROWS    = 32;
	localparam int PLANE_COUNT    = 8;

	localparam int ROW_PAIRS  = MATRIX_ROWS / 2;
	localparam int COL_W      = $clog2(MATRIX_COLUMNS);
	localparam int SROW_W     = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
	localparam int PLANE_W    = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

	// Each half of the panel lives in its own bank
	localparam int BANK_DEPTH = ROW_PAIRS * MATRIX_COLUMNS;
	localparam int ADDR_W     = $clog2(BANK_DEPTH);

	// Fixed field widths
	localparam int COORD_W    = 8;
	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int ROWADDR_W  = 4;
	localparam int BASE_W     = 10;
	localparam int ON_W       = 17;

	localparam logic [BASE_W-1:0] BASE_RESET = 10'd5;

	// Scan phases
	typedef enum logic [1:0] {
		PH_SHIFT = 2'd0,
		PH_LATCH = 2'd1,
		PH_ON    = 2'd2
	} phase_t;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified transaction handed from front to back
	typedef struct packed {
		logic                 is_write;
		logic                 reject;
		logic                 bank;
		logic [ADDR_W-1:0]    addr;
		logic [PLANE_W-1:0]   plane;
		logic [ROWADDR_W-1:0] row_addr;
		logic                 shift;
		logic                 latch;
		logic                 enable;
		logic [COLOR_W-1:0]   color;
	} op_t;

endpackage

>>> src/lmbs_front.sv
module lmbs_front import lmbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic signed [COORD_W-1:0] pixel_x,
	input  logic signed [COORD_W-1:0] pixel_y,
	input  logic [COLOR_W-1:0]        pixel_color,
	input  logic                      cfg_valid,
	input  logic [BASE_W-1:0]         cfg_data,
	input  logic                      clearing,
	input  logic                      q_full,
	output logic                      push,
	output op_t                       push_op
);

	localparam logic signed [9:0] COLS_S = 10'(MATRIX_COLUMNS);
	localparam logic signed [9:0] ROWS_S = 10'(MATRIX_ROWS);
	localparam logic signed [9:0] RP_S   = 10'(ROW_PAIRS);

	logic [BASE_W-1:0]  base_q;
	logic [SROW_W-1:0]  row_q, row_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	logic [COL_W-1:0]   col_q, col_d;
	phase_t             phase_q, phase_d;
	logic [ON_W-1:0]    left_q, left_d;

	logic               accept;
	logic               tick;
	logic signed [9:0]  x_ext, y_ext, y_sw, hy, hy_loc;
	logic               reject;
	logic               wr_bank;
	logic [9:0]         hy_bits;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [ON_W-1:0]    on_load;
	logic [SROW_W+ROWADDR_W-1:0] row_wide;
	logic               is_shift, is_latch, is_on;

	assign in_ready = !clearing && !q_full;
	assign accept   = in_valid && in_ready;
	assign tick     = accept && !kind;

	// Base on-time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// Pixel write: swap row pairs, flip row order, bound check
	always_comb begin
		x_ext   = 10'(pixel_x);
		y_ext   = 10'(pixel_y);
		y_sw    = pixel_y[0] ? (y_ext - 10'sd1) : (y_ext + 10'sd1);
		reject  = (x_ext < 10'sd0) || (x_ext >= COLS_S) ||
		          (y_sw < 10'sd0) || (y_sw >= ROWS_S);
		hy      = ROWS_S - 10'sd1 - y_sw;
		wr_bank = (hy >= RP_S);
		hy_loc  = wr_bank ? (hy - RP_S) : hy;
		hy_bits = hy_loc;
		wr_addr = ADDR_W'(hy_bits[SROW_W-1:0]) * ADDR_W'(MATRIX_COLUMNS) +
		          ADDR_W'(x_ext[COL_W-1:0]);
	end

	// Scan read address for the current column of both halves
	assign rd_addr  = ADDR_W'(row_q) * ADDR_W'(MATRIX_COLUMNS) + ADDR_W'(col_q);
	assign on_load  = ON_W'(base_q) << plane_q;
	assign row_wide = {ROWADDR_W'(0), row_q};

	// Scan sequencer next state
	always_comb begin
		row_d    = row_q;
		plane_d  = plane_q;
		col_d    = col_q;
		phase_d  = phase_q;
		left_d   = left_q;
		is_shift = 1'b0;
		is_latch = 1'b0;
		is_on    = 1'b0;
		unique case (phase_q)
			PH_LATCH: begin
				is_latch = 1'b1;
				left_d   = on_load;
				phase_d  = PH_ON;
			end
			PH_ON: begin
				is_on = 1'b1;
				if (left_q <= ON_W'(1)) begin
					left_d  = '0;
					phase_d = PH_SHIFT;
					if (plane_q == PLANE_W'(PLANE_COUNT - 1)) begin
						plane_d = '0;
						if (row_q == SROW_W'(ROW_PAIRS - 1)) begin
							row_d = '0;
						end else begin
							row_d = row_q + SROW_W'(1);
						end
					end else begin
						plane_d = plane_q + PLANE_W'(1);
					end
				end else begin
					left_d = left_q - ON_W'(1);
				end
			end
			default: begin
				is_shift = 1'b1;
				if (col_q == COL_W'(MATRIX_COLUMNS - 1)) begin
					col_d   = '0;
					phase_d = PH_LATCH;
				end else begin
					col_d   = col_q + COL_W'(1);
					phase_d = PH_SHIFT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			plane_q <= '0;
			col_q   <= '0;
			phase_q <= PH_SHIFT;
			left_q  <= '0;
		end else if (tick) begin
			row_q   <= row_d;
			plane_q <= plane_d;
			col_q   <= col_d;
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	// Classified transaction toward the queue
	always_comb begin
		push_op.is_write = kind;
		push_op.reject   = kind && reject;
		push_op.bank     = wr_bank;
		push_op.addr     = kind ? wr_addr : rd_addr;
		push_op.plane    = plane_q;
		push_op.row_addr = row_wide[ROWADDR_W-1:0];
		push_op.shift    = !kind && is_shift;
		push_op.latch    = !kind && is_latch;
		push_op.enable   = !kind && is_on;
		push_op.color    = pixel_color;
	end

	assign push = accept;

endmodule

>>> src/lmbs_queue.sv
module lmbs_queue import lmbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_op    = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> src/lmbs_back.sv
module lmbs_back import lmbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  op_t                  pop_op,
	output logic                 clearing,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROWADDR_W-1:0] row_address,
	output logic                 red_upper,
	output logic                 green_upper,
	output logic                 blue_upper,
	output logic                 red_lower,
	output logic                 green_lower,
	output logic                 blue_lower,
	output logic                 shift_clock,
	output logic                 latch_pulse,
	output logic                 display_enable,
	output logic                 write_rejected
);

	logic [COLOR_W-1:0] mem_up [BANK_DEPTH];
	logic [COLOR_W-1:0] mem_lo [BANK_DEPTH];

	logic               clearing_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               v_s1;
	op_t                op_s1;
	logic [COLOR_W-1:0] up_s1, lo_s1;
	logic               take;
	logic [CHAN_W-1:0]  r_up, g_up, b_up, r_lo, g_lo, b_lo;

	assign clearing  = clearing_q;
	assign pop_ready = !clearing_q && (!v_s1 || out_ready);
	assign take      = pop_valid && pop_ready;

	// Clearing pass over both banks after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == ADDR_W'(BANK_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Frame store banks: writes and registered column reads
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_up[clr_q] <= '0;
			mem_lo[clr_q] <= '0;
		end else if (take && pop_op.is_write && !pop_op.reject) begin
			if (pop_op.bank) begin
				mem_lo[pop_op.addr] <= pop_op.color;
			end else begin
				mem_up[pop_op.addr] <= pop_op.color;
			end
		end
		if (take && pop_op.shift) begin
			up_s1 <= mem_up[pop_op.addr];
			lo_s1 <= mem_lo[pop_op.addr];
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (out_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= pop_op;
		end
	end

	// Plane bit selection per channel
	assign r_up = up_s1[CHAN_W-1:0];
	assign g_up = up_s1[2*CHAN_W-1:CHAN_W];
	assign b_up = up_s1[3*CHAN_W-1:2*CHAN_W];
	assign r_lo = lo_s1[CHAN_W-1:0];
	assign g_lo = lo_s1[2*CHAN_W-1:CHAN_W];
	assign b_lo = lo_s1[3*CHAN_W-1:2*CHAN_W];

	assign out_valid      = v_s1;
	assign row_address    = op_s1.row_addr;
	assign red_upper      = op_s1.shift && r_up[op_s1.plane];
	assign green_upper    = op_s1.shift && g_up[op_s1.plane];
	assign blue_upper     = op_s1.shift && b_up[op_s1.plane];
	assign red_lower      = op_s1.shift && r_lo[op_s1.plane];
	assign green_lower    = op_s1.shift && g_lo[op_s1.plane];
	assign blue_lower     = op_s1.shift && b_lo[op_s1.plane];
	assign shift_clock    = op_s1.shift;
	assign latch_pulse    = op_s1.latch;
	assign display_enable = op_s1.enable;
	assign write_rejected = op_s1.is_write && op_s1.reject;

endmodule

>>> src/rgb_led_matrix_bitplane_scanner.sv
// Path: accepted transactions pass through the decoupling queue, then the result stage register.
// Throughput: one transaction per cycle while out_ready holds, ticks and pixel writes alike,
// set by the single write port and single read port of each half-panel frame store bank.
// Reset: asynchronous, active low; scan state returns to the first column, plane and row pair.
// After reset a clearing pass zeroes every address of both frame store banks with in_ready low;
// configuration writes are taken throughout.
module rgb_led_matrix_bitplane_scanner import lmbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic signed [COORD_W-1:0] pixel_x,
	input  logic signed [COORD_W-1:0] pixel_y,
	input  logic [COLOR_W-1:0]        pixel_color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ROWADDR_W-1:0]      row_address,
	output logic                      red_upper,
	output logic                      green_upper,
	output logic                      blue_upper,
	output logic                      red_lower,
	output logic                      green_lower,
	output logic                      blue_lower,
	output logic                      shift_clock,
	output logic                      latch_pulse,
	output logic                      display_enable,
	output logic                      write_rejected,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [BASE_W-1:0]         cfg_data
);

	logic clearing;
	logic q_full;
	logic push;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	assign cfg_ready = 1'b1;

	// Front: accept, classify, run the scan sequencer
	lmbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.clearing    (clearing),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op)
	);

	// Decoupling queue
	lmbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op)
	);

	// Back: frame store access and result register
	lmbs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_op         (pop_op),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row_address    (row_address),
		.red_upper      (red_upper),
		.green_upper    (green_upper),
		.blue_upper     (blue_upper),
		.red_lower      (red_lower),
		.green_lower    (green_lower),
		.blue_lower     (blue_lower),
		.shift_clock    (shift_clock),
		.latch_pulse    (latch_pulse),
		.display_enable (display_enable),
		.write_rejected (write_rejected)
	);

endmodule
